>>> sv/rsc_pkg.sv
package rsc_pkg;

    // Build-time geometry
    localparam int SIDE       = 256;
    localparam int WEDGES     = 5;
    localparam int ANGLE_BITS = 16;

    // Fixed field widths
    localparam int OFS_W    = 9;
    localparam int RADSQ_W  = 18;
    localparam int GAP_W    = 15;
    localparam int SECTOR_W = 3;
    localparam int CFG_IDX_W = 2;

    // Square bounds on the offsets
    localparam int SQ_LO = -(SIDE / 2);
    localparam int SQ_HI = SIDE - SIDE / 2;

    // CORDIC vectoring: inputs scaled by 2^FRAC_SH, 32-bit turn accumulator
    localparam int FRAC_SH         = 16;
    localparam int CW              = 28;
    localparam int ZW              = 32;
    localparam int CORDIC_STEPS    = 24;
    localparam int STEPS_PER_STAGE = 2;
    localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;

    localparam logic [ZW-1:0] Z_HALF_TURN = ZW'(1) << (ZW - 1);

    localparam logic [ANGLE_BITS-1:0] CENTER_ANGLE =
        ANGLE_BITS'((3 * (1 << ANGLE_BITS)) / 4);

    // Gap test widths: r * 2^16 against half_gap * WEDGES * 2^ANGLE_BITS
    localparam int PROD_W = ANGLE_BITS + SECTOR_W;
    localparam int CMP_W  = ANGLE_BITS + 20;

    // atan(2^-i) in 2^-32 of a turn
    localparam logic [ZW-1:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INNER_RADIUS_SQ = 2'd0,
        REG_OUTER_RADIUS_SQ = 2'd1,
        REG_HALF_GAP_ANGLE  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [RADSQ_W-1:0] inner_radius_sq;
        logic [RADSQ_W-1:0] outer_radius_sq;
        logic [GAP_W-1:0]   half_gap_angle;
    } rsc_cfg_t;

    typedef struct packed {
        logic                 ok;      // inside square and ring
        logic                 center;  // offset (0,0)
        logic signed [CW-1:0] u;
        logic signed [CW-1:0] v;
        logic [ZW-1:0]        z;
    } cordic_rec_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic                hit;
    } rsc_result_t;

    // One vectoring micro-rotation; step is a loop constant at every call site
    function automatic cordic_rec_t cordic_iter(input cordic_rec_t r, input int step);
        cordic_rec_t          n;
        logic signed [CW-1:0] u;
        logic signed [CW-1:0] v;
        logic signed [CW-1:0] du;
        logic signed [CW-1:0] dv;
        n  = r;
        u  = r.u;
        v  = r.v;
        du = v >>> step;
        dv = u >>> step;
        if (v != '0) begin
            if (!v[CW-1]) begin
                n.u = u + du;
                n.v = v - dv;
                n.z = r.z + ATAN_TURN[step[4:0]];
            end else begin
                n.u = u - du;
                n.v = v + dv;
                n.z = r.z - ATAN_TURN[step[4:0]];
            end
        end
        return n;
    endfunction

endpackage

>>> sv/rsc_prep.sv
module rsc_prep
    import rsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  in_valid,
    input  logic signed [OFS_W-1:0] offset_x,
    input  logic signed [OFS_W-1:0] offset_y,
    input  rsc_cfg_t              cfg,
    output logic                  out_valid,
    output cordic_rec_t           out_rec
);

    logic                    in_valid_reg;
    logic signed [OFS_W-1:0] dx_reg;
    logic signed [OFS_W-1:0] dy_reg;
    logic                    out_valid_reg;
    cordic_rec_t             rec_reg;
    cordic_rec_t             rec_next;

    logic signed [2*OFS_W-1:0] sqx;
    logic signed [2*OFS_W-1:0] sqy;
    logic [RADSQ_W-1:0]        r2;
    logic                      in_square;
    logic signed [CW-1:0]      u0;
    logic signed [CW-1:0]      v0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg  <= in_valid;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            dx_reg  <= offset_x;
            dy_reg  <= offset_y;
            rec_reg <= rec_next;
        end
    end

    always_comb begin
        in_square = (int'(dx_reg) >= SQ_LO) && (int'(dx_reg) < SQ_HI) &&
                    (int'(dy_reg) >= SQ_LO) && (int'(dy_reg) < SQ_HI);
        sqx = dx_reg * dx_reg;
        sqy = dy_reg * dy_reg;
        r2  = RADSQ_W'(sqx[2*OFS_W-2:0]) + RADSQ_W'(sqy[2*OFS_W-2:0]);

        // Rotate frame: up becomes +u, left becomes +v
        u0 = (-CW'(dy_reg)) <<< FRAC_SH;
        v0 = (-CW'(dx_reg)) <<< FRAC_SH;

        rec_next.ok     = in_square && (r2 >= cfg.inner_radius_sq) &&
                          (r2 <= cfg.outer_radius_sq);
        rec_next.center = (dx_reg == '0) && (dy_reg == '0);
        if (u0[CW-1]) begin
            rec_next.u = -u0;
            rec_next.v = -v0;
            rec_next.z = Z_HALF_TURN;
        end else begin
            rec_next.u = u0;
            rec_next.v = v0;
            rec_next.z = '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rec   = rec_reg;

endmodule

>>> sv/rsc_cordic.sv
module rsc_cordic
    import rsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  logic        in_valid,
    input  cordic_rec_t in_rec,
    output logic        out_valid,
    output cordic_rec_t out_rec
);

    logic        valid_reg [0:CORDIC_STAGES-1];
    cordic_rec_t rec_reg   [0:CORDIC_STAGES-1];
    cordic_rec_t rec_next  [0:CORDIC_STAGES-1];

    always_comb begin
        cordic_rec_t t;
        for (int k = 0; k < CORDIC_STAGES; k++) begin
            t = (k == 0) ? in_rec : rec_reg[(k == 0) ? 0 : k - 1];
            for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                t = cordic_iter(t, k * STEPS_PER_STAGE + j);
            end
            rec_next[k] = t;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CORDIC_STAGES; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (advance) begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < CORDIC_STAGES; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int k = 0; k < CORDIC_STAGES; k++) begin
                rec_reg[k] <= rec_next[k];
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_STAGES-1];
    assign out_rec   = rec_reg[CORDIC_STAGES-1];

endmodule

>>> sv/rsc_sector.sv
module rsc_sector
    import rsc_pkg::*;
(
    input  cordic_rec_t      rec,
    input  logic [GAP_W-1:0] half_gap_angle,
    output rsc_result_t      result
);

    logic [ANGLE_BITS-1:0] angle;
    logic [PROD_W-1:0]     prod;
    logic [SECTOR_W-1:0]   sect;
    logic [CMP_W-1:0]      lhs;
    logic [CMP_W-1:0]      gapw;
    logic [CMP_W-1:0]      full_turn;
    logic                  hit;

    always_comb begin
        angle = rec.center ? CENTER_ANGLE : rec.z[ZW-1 -: ANGLE_BITS];
        prod  = PROD_W'(angle) * PROD_W'(WEDGES);
        sect  = prod[PROD_W-1 -: SECTOR_W];

        // Remainder within the sector against half gap, both on a common scale
        lhs       = CMP_W'(prod[ANGLE_BITS-1:0]) << FRAC_SH;
        gapw      = (CMP_W'(half_gap_angle) * CMP_W'(WEDGES)) << ANGLE_BITS;
        full_turn = CMP_W'(1) << (ANGLE_BITS + FRAC_SH);

        hit = rec.ok && (lhs >= gapw) && ((lhs + gapw) <= full_turn);
        result.hit    = hit;
        result.sector = hit ? sect : '0;
    end

endmodule

>>> sv/rsc_out_buf.sv
module rsc_out_buf
    import rsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  rsc_result_t in_data,
    output logic        ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output rsc_result_t m_data
);

    logic        m_tvalid_reg;
    rsc_result_t m_data_reg;
    logic        skid_valid_reg;
    rsc_result_t skid_data_reg;
    logic        take;
    logic        m_free;

    assign take   = in_valid && !skid_valid_reg;
    assign m_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (m_free) begin
                    m_tvalid_reg   <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (take) begin
                if (m_free) begin
                    m_tvalid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_free) begin
                m_data_reg <= skid_data_reg;
            end
        end else if (take) begin
            if (m_free) begin
                m_data_reg <= in_data;
            end else begin
                skid_data_reg <= in_data;
            end
        end
    end

    assign ready    = !skid_valid_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_data   = m_data_reg;

    // Skid only ever backs up a held output beat
    a_skid_behind_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_tvalid_reg)
        else $error("skid holds a beat while output register is empty");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && m_tready |=> !skid_valid_reg)
        else $error("skid failed to drain on a taken beat");

    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && !skid_valid_reg && m_tvalid_reg && !m_tready |=> skid_valid_reg)
        else $error("result lost while output stalled");

    a_no_sector_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_data_reg.hit |-> m_data_reg.sector == '0)
        else $error("sector nonzero on a miss");

endmodule

>>> sv/ring_sector_classifier.sv
// Ring sector hit test: each input beat carries a pixel offset from the pie
// centre and yields one output beat with hit and sector index (0 when no hit).
// One beat is accepted every clock while s_tready is high; each beat passes
// through an input register, a setup stage (distance squared, square and
// ring test, half-plane fold), a 12-stage CORDIC vectoring pipeline at two
// micro-rotations per stage, and a sector/gap compare into the output
// register. A skid register behind the output lets one more result land
// while the output is held; s_tready drops only while that skid is occupied.
// Configuration writes are intended for idle periods only.
module ring_sector_classifier
    import rsc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RADSQ_W-1:0]   cfg_wdata,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // [8:0] offset_x, [17:9] offset_y, rest zero
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata    // [0] hit, [3:1] sector, rest zero
);

    rsc_cfg_t    cfg_reg;
    logic        advance;
    logic        prep_valid;
    cordic_rec_t prep_rec;
    logic        cordic_valid;
    cordic_rec_t cordic_rec;
    rsc_result_t result;
    rsc_result_t m_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.inner_radius_sq <= RADSQ_W'(4900);
            cfg_reg.outer_radius_sq <= RADSQ_W'(16384);
            cfg_reg.half_gap_angle  <= GAP_W'(447);
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_INNER_RADIUS_SQ: cfg_reg.inner_radius_sq <= cfg_wdata;
                REG_OUTER_RADIUS_SQ: cfg_reg.outer_radius_sq <= cfg_wdata;
                REG_HALF_GAP_ANGLE:  cfg_reg.half_gap_angle  <= cfg_wdata[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves together; it halts only while the skid is full
    assign s_tready = advance;

    rsc_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (s_tvalid),
        .offset_x  (s_tdata[8:0]),
        .offset_y  (s_tdata[17:9]),
        .cfg       (cfg_reg),
        .out_valid (prep_valid),
        .out_rec   (prep_rec)
    );

    rsc_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (prep_valid),
        .in_rec    (prep_rec),
        .out_valid (cordic_valid),
        .out_rec   (cordic_rec)
    );

    rsc_sector u_sector (
        .rec            (cordic_rec),
        .half_gap_angle (cfg_reg.half_gap_angle),
        .result         (result)
    );

    rsc_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (cordic_valid),
        .in_data  (result),
        .ready    (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_data   (m_data)
    );

    assign m_tdata = {4'b0000, m_data.sector, m_data.hit};

endmodule
